>>> rtl/rfvk_pkg.sv
// Shared constants and codes for the rotating frame velocity kernel.
// Holds default widths, operation codes, register indexes and the internal op kinds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfvk_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned CFG_IDX_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_COR_ADD  = 3'd0,
    OP_COR_SUB  = 3'd1,
    OP_RELATIVE = 3'd2,
    OP_ABSOLUTE = 3'd3,
    OP_SET_ROT  = 3'd4,
    OP_SET_ZERO = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_OMEGA_X  = 3'd1,
    CFG_OMEGA_Y  = 3'd2,
    CFG_OMEGA_Z  = 3'd3,
    CFG_ORIGIN_X = 3'd4,
    CFG_ORIGIN_Y = 3'd5,
    CFG_ORIGIN_Z = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_PASS    = 3'd0,
    KIND_ZERO    = 3'd1,
    KIND_COR_ADD = 3'd2,
    KIND_COR_SUB = 3'd3,
    KIND_REL     = 3'd4,
    KIND_ABS     = 3'd5,
    KIND_SET     = 3'd6
  } kind_t;

endpackage

`default_nettype wire

>>> rtl/rfvk_addsub.sv
// Saturating signed add or subtract with overflow flag.
// Uses rfvk_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none

module rfvk_addsub #(
  parameter int unsigned DATA_WIDTH = rfvk_pkg::DATA_WIDTH_DEF
) (
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  input  logic                         sub,
  output logic signed [DATA_WIDTH-1:0] y,
  output logic                         ovf
);

  localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH:0] ax;
  logic signed [DATA_WIDTH:0] bx;
  logic signed [DATA_WIDTH:0] sx;

  always_comb begin
    ax  = {a[DATA_WIDTH-1], a};
    bx  = {b[DATA_WIDTH-1], b};
    sx  = sub ? (ax - bx) : (ax + bx);
    ovf = sx[DATA_WIDTH] ^ sx[DATA_WIDTH-1];
    if (ovf) begin
      y = sx[DATA_WIDTH] ? MIN_V : MAX_V;
    end else begin
      y = sx[DATA_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rfvk_mul.sv
// Two-stage fixed-point multiplier: split partial products, then sum, floor shift, saturate.
// Uses rfvk_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module rfvk_mul #(
  parameter int unsigned DATA_WIDTH = rfvk_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = rfvk_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         pp_en,
  input  logic                         res_en,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0] p,
  output logic                         ovf
);

  localparam int unsigned LO_W = (DATA_WIDTH + 1) / 2;
  localparam int unsigned HI_W = DATA_WIDTH - LO_W;
  localparam int unsigned PW   = 2 * DATA_WIDTH;
  localparam int unsigned XW   = DATA_WIDTH + 1;
  localparam int unsigned LLW  = 2 * LO_W + 2;
  localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [HI_W-1:0]   a_hi;
  logic signed [HI_W-1:0]   b_hi;
  logic signed [LO_W:0]     a_lo;
  logic signed [LO_W:0]     b_lo;
  logic signed [2*HI_W-1:0] pp_hh_r;
  logic signed [XW-1:0]     pp_hl_r;
  logic signed [XW-1:0]     pp_lh_r;
  logic signed [LLW-1:0]    pp_ll_r;
  logic signed [PW-1:0]     full;
  logic signed [PW-1:0]     shifted;
  logic [PW-DATA_WIDTH:0]   top_bits;
  logic signed [DATA_WIDTH-1:0] p_nxt;
  logic                     ovf_nxt;
  logic signed [DATA_WIDTH-1:0] p_r;
  logic                     ovf_r;

  assign a_hi = a[DATA_WIDTH-1:LO_W];
  assign b_hi = b[DATA_WIDTH-1:LO_W];
  assign a_lo = {1'b0, a[LO_W-1:0]};
  assign b_lo = {1'b0, b[LO_W-1:0]};

  always_ff @(posedge clk) begin
    if (pp_en) begin
      pp_hh_r <= a_hi * b_hi;
      pp_hl_r <= a_hi * b_lo;
      pp_lh_r <= a_lo * b_hi;
      pp_ll_r <= a_lo * b_lo;
    end
  end

  always_comb begin
    full = ({{(PW-2*HI_W){pp_hh_r[2*HI_W-1]}}, pp_hh_r} << (2 * LO_W))
         + (({{(PW-XW){pp_hl_r[XW-1]}}, pp_hl_r}
           + {{(PW-XW){pp_lh_r[XW-1]}}, pp_lh_r}) << LO_W)
         + {{(PW-LLW){pp_ll_r[LLW-1]}}, pp_ll_r};
    shifted  = full >>> FRAC_BITS;
    top_bits = shifted[PW-1:DATA_WIDTH-1];
    ovf_nxt  = !(&top_bits) && (|top_bits);
    if (ovf_nxt) begin
      p_nxt = shifted[PW-1] ? MIN_V : MAX_V;
    end else begin
      p_nxt = shifted[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      p_r   <= p_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign p   = p_r;
  assign ovf = ovf_r;

endmodule

`default_nettype wire

>>> rtl/rotating_frame_velocity_kernel.sv
// Rotating frame velocity kernel: Coriolis source and frame velocity conversion, Q format.
// Top level; depends on rfvk_pkg, rfvk_addsub and rfvk_mul.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------
//   input   | in_op, in_base_*, in_arg_*, in_volume,  | in_valid / in_stall
//           | in_density                              |
//   result  | out_x, out_y, out_z, out_saturated      | out_valid / out_stall
//   config  | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
// Seven register stages; requests pass through them in order, one per cycle while out_stall is low.
// Most of the depth is the two chained two-stage multipliers (cross product, then scale).
// Each stage loads when empty or when the stage after it moves, so bubbles close under a stall.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
// Config writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module rotating_frame_velocity_kernel #(
  parameter int unsigned DATA_WIDTH = rfvk_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = rfvk_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rfvk_pkg::OP_W-1:0]          in_op,
  input  logic signed [DATA_WIDTH-1:0]       in_base_x,
  input  logic signed [DATA_WIDTH-1:0]       in_base_y,
  input  logic signed [DATA_WIDTH-1:0]       in_base_z,
  input  logic signed [DATA_WIDTH-1:0]       in_arg_x,
  input  logic signed [DATA_WIDTH-1:0]       in_arg_y,
  input  logic signed [DATA_WIDTH-1:0]       in_arg_z,
  input  logic signed [DATA_WIDTH-1:0]       in_volume,
  input  logic signed [DATA_WIDTH-1:0]       in_density,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [DATA_WIDTH-1:0]       out_x,
  output logic signed [DATA_WIDTH-1:0]       out_y,
  output logic signed [DATA_WIDTH-1:0]       out_z,
  output logic                               out_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfvk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_WIDTH-1:0]              cfg_data
);

  localparam int unsigned NST = 7;

  // configuration
  logic                         enable_r;
  logic signed [DATA_WIDTH-1:0] omega_r  [3];
  logic signed [DATA_WIDTH-1:0] origin_r [3];

  // pipeline control
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] rdy;

  // stage payload
  rfvk_pkg::kind_t kind_in, kind1_r, kind2_r, kind3_r, kind4_r, kind5_r, kind6_r;
  logic signed [DATA_WIDTH-1:0] base_in [3];
  logic signed [DATA_WIDTH-1:0] arg_in  [3];
  logic signed [DATA_WIDTH-1:0] diff    [3];
  logic signed [DATA_WIDTH-1:0] d_in    [3];
  logic signed [DATA_WIDTH-1:0] base1_r [3];
  logic signed [DATA_WIDTH-1:0] base2_r [3];
  logic signed [DATA_WIDTH-1:0] base3_r [3];
  logic signed [DATA_WIDTH-1:0] base4_r [3];
  logic signed [DATA_WIDTH-1:0] base5_r [3];
  logic signed [DATA_WIDTH-1:0] base6_r [3];
  logic signed [DATA_WIDTH-1:0] d1_r    [3];
  logic signed [DATA_WIDTH-1:0] cross_p [6];
  logic signed [DATA_WIDTH-1:0] c_in    [3];
  logic signed [DATA_WIDTH-1:0] c4_r    [3];
  logic signed [DATA_WIDTH-1:0] c5_r    [3];
  logic signed [DATA_WIDTH-1:0] c6_r    [3];
  logic signed [DATA_WIDTH-1:0] t_p     [3];
  logic signed [DATA_WIDTH-1:0] fin_b   [3];
  logic signed [DATA_WIDTH-1:0] fin_y   [3];
  logic signed [DATA_WIDTH-1:0] res_nxt [3];
  logic signed [DATA_WIDTH-1:0] res7_r  [3];
  logic signed [DATA_WIDTH-1:0] s_p;
  logic signed [DATA_WIDTH-1:0] s3_r;
  logic signed [DATA_WIDTH-1:0] s4_r;
  logic [2:0] diff_ovf;
  logic [5:0] cross_ovf;
  logic [2:0] c_ovf;
  logic [2:0] t_ovf;
  logic [2:0] fin_ovf;
  logic       s_ovf;
  logic       frame_in, cor2, act3, cor6, fin_use6, fin_sub6;
  logic       flag_in, flag1_r, flag2_r, flag3_r, flag4_r, flag5_r, flag6_r, flag7_r;
  logic       flag7_nxt;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      omega_r  <= '{default: '0};
      origin_r <= '{default: '0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfvk_pkg::CFG_ENABLE:   enable_r    <= cfg_data[0];
        rfvk_pkg::CFG_OMEGA_X:  omega_r[0]  <= cfg_data;
        rfvk_pkg::CFG_OMEGA_Y:  omega_r[1]  <= cfg_data;
        rfvk_pkg::CFG_OMEGA_Z:  omega_r[2]  <= cfg_data;
        rfvk_pkg::CFG_ORIGIN_X: origin_r[0] <= cfg_data;
        rfvk_pkg::CFG_ORIGIN_Y: origin_r[1] <= cfg_data;
        rfvk_pkg::CFG_ORIGIN_Z: origin_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NST-1];

  // ---------------------------------------------------------------- stage 1: decode, arg - origin
  assign base_in[0] = in_base_x;
  assign base_in[1] = in_base_y;
  assign base_in[2] = in_base_z;
  assign arg_in[0]  = in_arg_x;
  assign arg_in[1]  = in_arg_y;
  assign arg_in[2]  = in_arg_z;

  always_comb begin
    kind_in = rfvk_pkg::KIND_PASS;
    if (enable_r) begin
      unique case (in_op)
        rfvk_pkg::OP_COR_ADD:  kind_in = rfvk_pkg::KIND_COR_ADD;
        rfvk_pkg::OP_COR_SUB:  kind_in = rfvk_pkg::KIND_COR_SUB;
        rfvk_pkg::OP_RELATIVE: kind_in = rfvk_pkg::KIND_REL;
        rfvk_pkg::OP_ABSOLUTE: kind_in = rfvk_pkg::KIND_ABS;
        rfvk_pkg::OP_SET_ROT:  kind_in = rfvk_pkg::KIND_SET;
        rfvk_pkg::OP_SET_ZERO: kind_in = rfvk_pkg::KIND_ZERO;
        default:               kind_in = rfvk_pkg::KIND_PASS;
      endcase
    end
  end

  assign frame_in = (kind_in == rfvk_pkg::KIND_REL) || (kind_in == rfvk_pkg::KIND_ABS)
                 || (kind_in == rfvk_pkg::KIND_SET);

  for (genvar i = 0; i < 3; i++) begin : g_diff
    rfvk_addsub #(.DATA_WIDTH(DATA_WIDTH)) u_diff (
      .a   (arg_in[i]),
      .b   (origin_r[i]),
      .sub (1'b1),
      .y   (diff[i]),
      .ovf (diff_ovf[i])
    );
    assign d_in[i] = frame_in ? diff[i] : arg_in[i];
  end

  assign flag_in = frame_in && (|diff_ovf);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      kind1_r <= kind_in;
      base1_r <= base_in;
      d1_r    <= d_in;
      flag1_r <= flag_in;
    end
  end

  // volume * density, stages 1 and 2
  rfvk_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_s (
    .clk    (clk),
    .pp_en  (rdy[0]),
    .res_en (rdy[1]),
    .a      (in_volume),
    .b      (in_density),
    .p      (s_p),
    .ovf    (s_ovf)
  );

  // ---------------------------------------------------------------- stages 2 and 3: omega x d
  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    rfvk_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_pos (
      .clk    (clk),
      .pp_en  (rdy[1]),
      .res_en (rdy[2]),
      .a      (omega_r[J]),
      .b      (d1_r[K]),
      .p      (cross_p[2*i]),
      .ovf    (cross_ovf[2*i])
    );
    rfvk_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_neg (
      .clk    (clk),
      .pp_en  (rdy[1]),
      .res_en (rdy[2]),
      .a      (omega_r[K]),
      .b      (d1_r[J]),
      .p      (cross_p[2*i+1]),
      .ovf    (cross_ovf[2*i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      kind2_r <= kind1_r;
      base2_r <= base1_r;
      flag2_r <= flag1_r;
    end
  end

  assign cor2 = (kind2_r == rfvk_pkg::KIND_COR_ADD) || (kind2_r == rfvk_pkg::KIND_COR_SUB);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      kind3_r <= kind2_r;
      base3_r <= base2_r;
      s3_r    <= s_p;
      flag3_r <= flag2_r || (cor2 && s_ovf);
    end
  end

  // ---------------------------------------------------------------- stage 4: cross differences
  for (genvar i = 0; i < 3; i++) begin : g_cdiff
    rfvk_addsub #(.DATA_WIDTH(DATA_WIDTH)) u_cdiff (
      .a   (cross_p[2*i]),
      .b   (cross_p[2*i+1]),
      .sub (1'b1),
      .y   (c_in[i]),
      .ovf (c_ovf[i])
    );
  end

  assign act3 = (kind3_r != rfvk_pkg::KIND_PASS) && (kind3_r != rfvk_pkg::KIND_ZERO);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      kind4_r <= kind3_r;
      base4_r <= base3_r;
      s4_r    <= s3_r;
      c4_r    <= c_in;
      flag4_r <= flag3_r || (act3 && ((|cross_ovf) || (|c_ovf)));
    end
  end

  // ---------------------------------------------------------------- stages 5 and 6: s * c
  for (genvar i = 0; i < 3; i++) begin : g_term
    rfvk_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_t (
      .clk    (clk),
      .pp_en  (rdy[4]),
      .res_en (rdy[5]),
      .a      (s4_r),
      .b      (c4_r[i]),
      .p      (t_p[i]),
      .ovf    (t_ovf[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      kind5_r <= kind4_r;
      base5_r <= base4_r;
      c5_r    <= c4_r;
      flag5_r <= flag4_r;
    end
    if (rdy[5]) begin
      kind6_r <= kind5_r;
      base6_r <= base5_r;
      c6_r    <= c5_r;
      flag6_r <= flag5_r;
    end
  end

  // ---------------------------------------------------------------- stage 7: combine with base
  assign cor6     = (kind6_r == rfvk_pkg::KIND_COR_ADD) || (kind6_r == rfvk_pkg::KIND_COR_SUB);
  assign fin_sub6 = (kind6_r == rfvk_pkg::KIND_COR_SUB) || (kind6_r == rfvk_pkg::KIND_REL);
  assign fin_use6 = cor6 || (kind6_r == rfvk_pkg::KIND_REL) || (kind6_r == rfvk_pkg::KIND_ABS);

  for (genvar i = 0; i < 3; i++) begin : g_fin
    assign fin_b[i] = cor6 ? t_p[i] : c6_r[i];
    rfvk_addsub #(.DATA_WIDTH(DATA_WIDTH)) u_fin (
      .a   (base6_r[i]),
      .b   (fin_b[i]),
      .sub (fin_sub6),
      .y   (fin_y[i]),
      .ovf (fin_ovf[i])
    );
  end

  always_comb begin
    unique case (kind6_r)
      rfvk_pkg::KIND_COR_ADD,
      rfvk_pkg::KIND_COR_SUB,
      rfvk_pkg::KIND_REL,
      rfvk_pkg::KIND_ABS:  res_nxt = fin_y;
      rfvk_pkg::KIND_SET:  res_nxt = c6_r;
      rfvk_pkg::KIND_ZERO: res_nxt = '{default: '0};
      default:             res_nxt = base6_r;
    endcase
    flag7_nxt = flag6_r || (cor6 && (|t_ovf)) || (fin_use6 && (|fin_ovf));
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      res7_r  <= res_nxt;
      flag7_r <= flag7_nxt;
    end
  end

  assign out_x         = res7_r[0];
  assign out_y         = res7_r[1];
  assign out_z         = res7_r[2];
  assign out_saturated = flag7_r;

endmodule

`default_nettype wire

>>> tb/tb_rotating_frame_velocity_kernel.sv
// Self-checking bench for rotating_frame_velocity_kernel: a scripted table of requests, then
// random requests under random idling and register settings, scored against a local model.
// Depends on rfvk_pkg and the kernel RTL.
`timescale 1ns / 1ps

module tb_rotating_frame_velocity_kernel;

  localparam int unsigned W    = rfvk_pkg::DATA_WIDTH_DEF;
  localparam int unsigned FRAC = rfvk_pkg::FRAC_BITS_DEF;
  localparam int unsigned OPW  = rfvk_pkg::OP_W;
  localparam int unsigned IDXW = rfvk_pkg::CFG_IDX_W;

  localparam logic signed [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] Q_ONE = W'(1) << FRAC;
  localparam longint LIM_HI = (longint'(1) <<< (W-1)) - 1;
  localparam longint LIM_LO = -(longint'(1) <<< (W-1));

  localparam logic [OPW-1:0]  OP_SPARE_6    = 3'd6;
  localparam logic [OPW-1:0]  OP_SPARE_7    = 3'd7;
  localparam logic [IDXW-1:0] CFG_SPARE_IDX = 3'd7;

  localparam int SCRIPT_LEN     = 25;
  localparam int RAND_PER_ZONE  = 127;
  localparam int HOLD_LEN       = 150;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [OPW-1:0]      op;
    logic signed [W-1:0] bx, by, bz, ax, ay, az, vol, den;
  } cell_req_t;

  typedef struct packed {
    logic signed [W-1:0] x, y, z;
    logic                sat;
  } vec_out_t;

  typedef struct {
    int        sel;
    cell_req_t req;
    bit        typed;
    vec_out_t  want;
  } script_row_t;

  typedef struct {
    bit                  en;
    logic signed [W-1:0] wx, wy, wz, ox, oy, oz;
  } zone_cfg_t;

  localparam vec_out_t NO_WANT = '0;
  localparam vec_out_t ZERO_OUT = '0;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OPW-1:0]       in_op = rfvk_pkg::OP_COR_ADD;
  logic signed [W-1:0]  in_base_x = '0, in_base_y = '0, in_base_z = '0;
  logic signed [W-1:0]  in_arg_x = '0, in_arg_y = '0, in_arg_z = '0;
  logic signed [W-1:0]  in_volume = '0, in_density = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [W-1:0]  out_x, out_y, out_z;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDXW-1:0]      cfg_index = rfvk_pkg::CFG_ENABLE;
  logic [W-1:0]         cfg_data = '0;

  bit                  zone_en = 1'b1;
  logic signed [W-1:0] zone_w [3] = '{default: '0};
  logic signed [W-1:0] zone_o [3] = '{default: '0};
  bit                  pred_clipped;

  vec_out_t predicted_q [$];
  int       mismatches = 0;
  int       requests_sent = 0;
  int       results_checked = 0;
  int       zones_loaded = 0;
  int       snd_idle_pct = 0;
  int       rcv_idle_pct = 0;
  bit       hold_go = 1'b0;
  bit       hold_seen = 1'b0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  zone_cfg_t presets [5] = '{
    '{1'b1, '0, '0, '0, '0, '0, '0},
    '{1'b0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN},
    '{1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN},
    '{1'b1, '0, '0, Q_ONE, Q_ONE, 2 * Q_ONE, -3 * Q_ONE},
    '{1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX}
  };

  script_row_t script [SCRIPT_LEN] = '{
    '{0, '{rfvk_pkg::OP_SET_ZERO, Q_MAX, Q_MIN, -32'sd1, Q_MAX, Q_MAX, Q_MAX, Q_ONE,
      Q_ONE}, 1'b1, ZERO_OUT},
    '{0, '{OP_SPARE_6, Q_MAX, Q_MIN, 32'sd0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX},
      1'b1, '{Q_MAX, Q_MIN, 32'sd0, 1'b0}},
    '{0, '{OP_SPARE_7, 32'sh1234_5678, -32'sh0ABC_DEF0, Q_ONE, 32'sd0, 32'sd0, 32'sd0,
      32'sd0, 32'sd0}, 1'b1, '{32'sh1234_5678, -32'sh0ABC_DEF0, Q_ONE, 1'b0}},
    '{0, '{rfvk_pkg::OP_COR_ADD, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX},
      1'b1, '{Q_MAX, Q_MIN, Q_ONE, 1'b1}},
    '{0, '{rfvk_pkg::OP_COR_SUB, Q_MIN, Q_MAX, 32'sd0, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN},
      1'b1, '{Q_MIN, Q_MAX, 32'sd0, 1'b1}},
    '{0, '{rfvk_pkg::OP_COR_ADD, -32'sd5, 32'sh7FFF_0000, Q_ONE, 32'sh0003_0000,
      -32'sh0002_0000, Q_ONE, Q_ONE, Q_ONE}, 1'b1, '{-32'sd5, 32'sh7FFF_0000, Q_ONE, 1'b0}},
    '{0, '{rfvk_pkg::OP_RELATIVE, Q_MAX, Q_MIN, 32'sd7, Q_MIN, Q_MAX, 32'sd0, Q_ONE, Q_ONE},
      1'b1, '{Q_MAX, Q_MIN, 32'sd7, 1'b0}},
    '{0, '{rfvk_pkg::OP_ABSOLUTE, Q_MIN, Q_MAX, -32'sd7, Q_MAX, Q_MIN, -32'sd1, Q_ONE,
      Q_ONE}, 1'b1, '{Q_MIN, Q_MAX, -32'sd7, 1'b0}},
    '{0, '{rfvk_pkg::OP_SET_ROT, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_ONE, Q_ONE, Q_ONE},
      1'b1, ZERO_OUT},
    '{1, '{rfvk_pkg::OP_COR_ADD, 32'sd1, 32'sd2, 32'sd3, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX},
      1'b1, '{32'sd1, 32'sd2, 32'sd3, 1'b0}},
    '{1, '{rfvk_pkg::OP_SET_ZERO, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MAX, Q_MAX, Q_ONE, Q_ONE},
      1'b1, '{Q_MAX, Q_MIN, Q_ONE, 1'b0}},
    '{1, '{rfvk_pkg::OP_SET_ROT, -Q_ONE, Q_ONE, 32'sd0, Q_MAX, Q_MAX, Q_MAX, Q_ONE, Q_ONE},
      1'b1, '{-Q_ONE, Q_ONE, 32'sd0, 1'b0}},
    '{1, '{rfvk_pkg::OP_RELATIVE, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_ONE, Q_ONE},
      1'b1, '{Q_MIN, Q_MIN, Q_MIN, 1'b0}},
    '{2, '{rfvk_pkg::OP_COR_ADD, Q_MAX, Q_MIN, 32'sd0, Q_MAX, Q_MIN, Q_ONE, Q_ONE, Q_ONE},
      1'b0, NO_WANT},
    '{2, '{rfvk_pkg::OP_COR_SUB, Q_MIN, Q_MAX, Q_ONE, Q_MIN, Q_MIN, Q_MAX, -Q_ONE, Q_MAX},
      1'b0, NO_WANT},
    '{2, '{rfvk_pkg::OP_RELATIVE, 32'sd0, 32'sd0, 32'sd0, Q_MAX, Q_MAX, Q_MAX, Q_ONE,
      Q_ONE}, 1'b0, NO_WANT},
    '{2, '{rfvk_pkg::OP_ABSOLUTE, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_ONE, Q_ONE},
      1'b0, NO_WANT},
    '{2, '{rfvk_pkg::OP_SET_ROT, Q_MIN, Q_MIN, Q_MIN, 32'sd0, 32'sd0, 32'sd0, Q_ONE, Q_ONE},
      1'b0, NO_WANT},
    '{2, '{rfvk_pkg::OP_SET_ZERO, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX},
      1'b1, ZERO_OUT},
    '{3, '{rfvk_pkg::OP_COR_ADD, Q_ONE, -32'sh0000_8000, 32'sd0, 32'sh0003_0000,
      -32'sh0002_0000, Q_ONE, 32'sh0002_0000, 32'sh0000_8000}, 1'b0, NO_WANT},
    '{3, '{rfvk_pkg::OP_RELATIVE, 32'sh0005_0000, 32'sh0004_0000, -Q_ONE,
      32'sh0004_0000, -Q_ONE, 32'sh0002_0000, Q_ONE, Q_ONE}, 1'b0, NO_WANT},
    '{3, '{rfvk_pkg::OP_ABSOLUTE, 32'sh0005_0000, 32'sh0004_0000, -Q_ONE,
      -32'sh0002_0000, 32'sh0006_0000, 32'sd0, Q_ONE, Q_ONE}, 1'b0, NO_WANT},
    '{3, '{rfvk_pkg::OP_SET_ROT, 32'sd0, 32'sd0, 32'sd0, 32'sh0001_8000, 32'sh0002_8000,
      -32'sh0000_8000, Q_ONE, Q_ONE}, 1'b0, NO_WANT},
    '{4, '{rfvk_pkg::OP_COR_SUB, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN},
      1'b0, NO_WANT},
    '{4, '{rfvk_pkg::OP_ABSOLUTE, 32'sd0, Q_ONE, -Q_ONE, Q_MIN, Q_MIN, Q_MIN, Q_ONE, Q_ONE},
      1'b0, NO_WANT}
  };

  rotating_frame_velocity_kernel uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_base_x    (in_base_x),
    .in_base_y    (in_base_y),
    .in_base_z    (in_base_z),
    .in_arg_x     (in_arg_x),
    .in_arg_y     (in_arg_y),
    .in_arg_z     (in_arg_z),
    .in_volume    (in_volume),
    .in_density   (in_density),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_saturated(out_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [W-1:0] clip_q(input longint v);
    if (v > LIM_HI) begin
      pred_clipped = 1'b1;
      return Q_MAX;
    end
    if (v < LIM_LO) begin
      pred_clipped = 1'b1;
      return Q_MIN;
    end
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a, b);
    return clip_q((longint'(a) * longint'(b)) >>> FRAC);
  endfunction

  function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a, b);
    return clip_q(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] a, b);
    return clip_q(longint'(a) - longint'(b));
  endfunction

  function automatic void omega_cross(input logic signed [W-1:0] v [3],
                                      output logic signed [W-1:0] c [3]);
    c[0] = qsub(qmul(zone_w[1], v[2]), qmul(zone_w[2], v[1]));
    c[1] = qsub(qmul(zone_w[2], v[0]), qmul(zone_w[0], v[2]));
    c[2] = qsub(qmul(zone_w[0], v[1]), qmul(zone_w[1], v[0]));
  endfunction

  function automatic vec_out_t predict_velocity(input cell_req_t r);
    logic signed [W-1:0] base [3];
    logic signed [W-1:0] arg [3];
    logic signed [W-1:0] d [3];
    logic signed [W-1:0] c [3];
    logic signed [W-1:0] res [3];
    logic signed [W-1:0] scale;
    int i;
    base = '{r.bx, r.by, r.bz};
    arg = '{r.ax, r.ay, r.az};
    res = base;
    pred_clipped = 1'b0;
    if (zone_en) begin
      case (r.op)
        rfvk_pkg::OP_COR_ADD, rfvk_pkg::OP_COR_SUB: begin
          scale = qmul(r.vol, r.den);
          omega_cross(arg, c);
          for (i = 0; i < 3; i++) begin
            if (r.op == rfvk_pkg::OP_COR_ADD) res[i] = qadd(base[i], qmul(scale, c[i]));
            else res[i] = qsub(base[i], qmul(scale, c[i]));
          end
        end
        rfvk_pkg::OP_RELATIVE, rfvk_pkg::OP_ABSOLUTE, rfvk_pkg::OP_SET_ROT: begin
          for (i = 0; i < 3; i++) d[i] = qsub(arg[i], zone_o[i]);
          omega_cross(d, c);
          for (i = 0; i < 3; i++) begin
            if (r.op == rfvk_pkg::OP_RELATIVE) res[i] = qsub(base[i], c[i]);
            else if (r.op == rfvk_pkg::OP_ABSOLUTE) res[i] = qadd(base[i], c[i]);
            else res[i] = c[i];
          end
        end
        rfvk_pkg::OP_SET_ZERO: begin
          for (i = 0; i < 3; i++) res[i] = '0;
        end
        default: ;
      endcase
    end
    return '{res[0], res[1], res[2], pred_clipped};
  endfunction

  function automatic logic signed [W-1:0] pick_word();
    logic signed [W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return -1;
          4: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      1, 2: return raw;
      default: return raw >>> $urandom_range(8, 14);
    endcase
  endfunction

  function automatic cell_req_t make_random_request();
    cell_req_t r;
    if ($urandom_range(0, 15) == 0) r.op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
    else r.op = OPW'($urandom_range(rfvk_pkg::OP_COR_ADD, rfvk_pkg::OP_SET_ZERO));
    r.bx = pick_word();
    r.by = pick_word();
    r.bz = pick_word();
    r.ax = pick_word();
    r.ay = pick_word();
    r.az = pick_word();
    r.vol = ($urandom_range(0, 4) < 2) ? Q_ONE : pick_word();
    r.den = ($urandom_range(0, 4) < 2) ? Q_ONE : pick_word();
    return r;
  endfunction

  function automatic zone_cfg_t make_random_zone();
    zone_cfg_t z;
    z.en = ($urandom_range(0, 5) != 0);
    z.wx = pick_word();
    z.wy = pick_word();
    z.wz = pick_word();
    z.ox = pick_word();
    z.oy = pick_word();
    z.oz = pick_word();
    return z;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got, want);
    mismatches++;
    $display("%0t: %0s got %h expected %h", $time, what, got, want);
  endtask

  task automatic check_result();
    vec_out_t want;
    results_checked++;
    if (predicted_q.size() == 0) begin
      report_mismatch("result with no request pending, out_x", out_x, '0);
    end else begin
      want = predicted_q.pop_front();
      if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
      if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
      if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
      if (out_saturated !== want.sat)
        report_mismatch("out_saturated", W'(out_saturated), W'(want.sat));
    end
  endtask

  task automatic push_request(input cell_req_t r, input bit typed, input vec_out_t want);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= r.op;
    in_base_x  <= r.bx;
    in_base_y  <= r.by;
    in_base_z  <= r.bz;
    in_arg_x   <= r.ax;
    in_arg_y   <= r.ay;
    in_arg_z   <= r.az;
    in_volume  <= r.vol;
    in_density <= r.den;
    do @(posedge clk); while (in_stall);
    predicted_q.push_back(typed ? want : predict_velocity(r));
    requests_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rfvk_pkg::CFG_ENABLE:   zone_en = val[0];
      rfvk_pkg::CFG_OMEGA_X:  zone_w[0] = val;
      rfvk_pkg::CFG_OMEGA_Y:  zone_w[1] = val;
      rfvk_pkg::CFG_OMEGA_Z:  zone_w[2] = val;
      rfvk_pkg::CFG_ORIGIN_X: zone_o[0] = val;
      rfvk_pkg::CFG_ORIGIN_Y: zone_o[1] = val;
      rfvk_pkg::CFG_ORIGIN_Z: zone_o[2] = val;
      default: ;
    endcase
  endtask

  task automatic load_zone(input zone_cfg_t z);
    logic [W-1:0] en_word;
    en_word = $urandom;
    en_word[0] = z.en;
    drain_pipeline();
    write_reg(rfvk_pkg::CFG_ENABLE, en_word);
    write_reg(rfvk_pkg::CFG_OMEGA_X, z.wx);
    write_reg(rfvk_pkg::CFG_OMEGA_Y, z.wy);
    write_reg(rfvk_pkg::CFG_OMEGA_Z, z.wz);
    write_reg(rfvk_pkg::CFG_ORIGIN_X, z.ox);
    write_reg(rfvk_pkg::CFG_ORIGIN_Y, z.oy);
    write_reg(rfvk_pkg::CFG_ORIGIN_Z, z.oz);
    write_reg(CFG_SPARE_IDX, $urandom);
    cfg_valid <= 1'b0;
    zones_loaded++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_go != hold_seen) begin
        hold_seen <= hold_go;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int mode;
    int phase;
    int zone_sel;
    zone_sel = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct <= 30;
    rcv_idle_pct <= 59;

    for (n = 0; n < SCRIPT_LEN; n++) begin
      if (script[n].sel != zone_sel) begin
        load_zone(presets[script[n].sel]);
        zone_sel = script[n].sel;
      end
      push_request(script[n].req, script[n].typed, script[n].want);
    end

    for (mode = 0; mode < 3; mode++) begin
      snd_idle_pct <= (mode == 0) ? 30 : (mode == 1) ? 59 : 0;
      rcv_idle_pct <= (mode == 0) ? 59 : (mode == 1) ? 30 : 0;
      for (phase = 0; phase < 4; phase++) begin
        load_zone(make_random_zone());
        // back up the pipeline while requests keep coming
        if (phase == 0) hold_go <= ~hold_go;
        repeat (RAND_PER_ZONE) push_request(make_random_request(), 1'b0, NO_WANT);
      end
    end

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_q.size() != 0)
      report_mismatch("results never delivered, count", predicted_q.size(), '0);
    $display("%0d requests under %0d register settings, %0d results compared, %0d mismatches",
             requests_sent, zones_loaded + 1, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> rotating_frame_velocity_kernel.f
rtl/rfvk_pkg.sv
rtl/rfvk_addsub.sv
rtl/rfvk_mul.sv
rtl/rotating_frame_velocity_kernel.sv
tb/tb_rotating_frame_velocity_kernel.sv
